@@ hw/rtl/fbl_pkg.sv @@
// shared types, codes and tables of the bit-file loader
package fbl_pkg;

    // input word as it arrives on the push side
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] file_byte;
        logic       init_pin;
        logic       done_pin;
    } t_in_word;

    // result word as it leaves on the pop side
    typedef struct packed {
        logic        accepted;
        logic        serial_valid;
        logic [7:0]  serial_byte;
        logic        prog_level;
        logic [3:0]  status;
        logic [31:0] expected_size;
        logic [31:0] bytes_sent;
    } t_out_word;

    // raw op codes on the input
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_EOF  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // classified command kind handed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_EOF,
        CMD_TICK,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic       init_hi;
        logic       done_hi;
    } t_cmd;

    // loader phases
    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_KEY,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_FINAL_KEY,
        PH_SIZE,
        PH_AWAIT_LOW,
        PH_AWAIT_HIGH,
        PH_SETTLE,
        PH_STREAM,
        PH_DUMMY,
        PH_OK,
        PH_BAD,
        PH_TRUNC,
        PH_INITFAIL
    } t_phase;

    // status codes reported in each result word
    localparam logic [3:0] ST_HEADER     = 4'd0;
    localparam logic [3:0] ST_AWAIT_LOW  = 4'd1;
    localparam logic [3:0] ST_AWAIT_HIGH = 4'd2;
    localparam logic [3:0] ST_STREAM     = 4'd3;
    localparam logic [3:0] ST_DUMMY      = 4'd4;
    localparam logic [3:0] ST_OK         = 4'd5;
    localparam logic [3:0] ST_BAD        = 4'd6;
    localparam logic [3:0] ST_TRUNC      = 4'd7;
    localparam logic [3:0] ST_INITFAIL   = 4'd8;

    localparam logic [3:0] MAGIC_LEN     = 4'd13;
    localparam logic [7:0] DUMMY_BYTE    = 8'hFF;
    localparam logic [7:0] SETTLE_RESET  = 8'd5;
    localparam logic [3:0] SIZE_BYTES    = 4'd4;

    // fixed bit-file header bytes
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h00;
            4'd1:    b = 8'h09;
            4'd2:    b = 8'h0F;
            4'd3:    b = 8'hF0;
            4'd4:    b = 8'h0F;
            4'd5:    b = 8'hF0;
            4'd6:    b = 8'h0F;
            4'd7:    b = 8'hF0;
            4'd8:    b = 8'h0F;
            4'd9:    b = 8'hF0;
            4'd10:   b = 8'h00;
            4'd11:   b = 8'h00;
            4'd12:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // status code seen from outside for each phase
    function automatic logic [3:0] status_of(input t_phase ph);
        logic [3:0] s;
        unique case (ph)
            PH_AWAIT_LOW:              s = ST_AWAIT_LOW;
            PH_AWAIT_HIGH, PH_SETTLE:  s = ST_AWAIT_HIGH;
            PH_STREAM:                 s = ST_STREAM;
            PH_DUMMY:                  s = ST_DUMMY;
            PH_OK:                     s = ST_OK;
            PH_BAD:                    s = ST_BAD;
            PH_TRUNC:                  s = ST_TRUNC;
            PH_INITFAIL:               s = ST_INITFAIL;
            default:                   s = ST_HEADER;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/fbl_fifo.sv @@
// small register queue used between the loader stages
module fbl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ hw/rtl/fbl_front.sv @@
// front stage: takes input words and turns them into loader commands
module fbl_front (
    input  logic              i_push,
    input  fbl_pkg::t_in_word i_word,
    input  logic              i_cmd_full,
    output logic              o_full,
    output logic              o_cmd_push,
    output fbl_pkg::t_cmd     o_cmd
);

    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push;

    // classify the op code, unused code becomes a no-op
    always_comb begin
        unique case (i_word.op)
            fbl_pkg::OP_BYTE: o_cmd.kind = fbl_pkg::CMD_BYTE;
            fbl_pkg::OP_EOF:  o_cmd.kind = fbl_pkg::CMD_EOF;
            fbl_pkg::OP_TICK: o_cmd.kind = fbl_pkg::CMD_TICK;
            default:          o_cmd.kind = fbl_pkg::CMD_NOP;
        endcase
        o_cmd.data    = i_word.file_byte;
        o_cmd.init_hi = i_word.init_pin;
        o_cmd.done_hi = i_word.done_pin;
    end

endmodule

@@ hw/rtl/fbl_engine.sv @@
// back stage: header parser, PROG/INIT sequencer and stream forwarder
module fbl_engine #(
    parameter int HEADER_CHUNKS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_cmd_valid,
    input  fbl_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output fbl_pkg::t_out_word o_res
);

    localparam logic [2:0] CHUNKS_LAST = 3'(HEADER_CHUNKS);

    fbl_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_byte_idx, n_byte_idx;
    logic [2:0]  r_chunk, n_chunk;
    logic [15:0] r_skip, n_skip;
    logic [31:0] r_size, n_size;
    logic [31:0] r_sent, n_sent;
    logic [7:0]  r_settle, n_settle;
    logic        r_prog, n_prog;
    logic [7:0]  r_settle_ticks;
    logic        go;
    logic        accepted, svalid;
    logic [7:0]  sbyte;
    logic [2:0]  chunk_inc;
    logic [3:0]  idx_inc;
    logic [15:0] skip_full;
    logic [15:0] skip_dec;
    logic [7:0]  settle_dec;

    assign go         = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = go;
    assign o_res_push = go;

    assign chunk_inc  = r_chunk + 3'd1;
    assign idx_inc    = r_byte_idx + 4'd1;
    assign skip_full  = {r_skip[15:8], i_cmd.data};
    assign skip_dec   = r_skip - 16'd1;
    assign settle_dec = (r_settle != 8'd0) ? r_settle - 8'd1 : r_settle;

    // next state and result word for the command at the queue head
    always_comb begin
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_chunk    = r_chunk;
        n_skip     = r_skip;
        n_size     = r_size;
        n_sent     = r_sent;
        n_settle   = r_settle;
        n_prog     = r_prog;
        accepted   = 1'b0;
        svalid     = 1'b0;
        sbyte      = 8'h00;

        unique case (i_cmd.kind)
            fbl_pkg::CMD_BYTE: begin
                if (r_phase <= fbl_pkg::PH_SIZE) begin
                    accepted = 1'b1;
                    unique case (r_phase)
                        fbl_pkg::PH_MAGIC: begin
                            if (r_byte_idx >= fbl_pkg::MAGIC_LEN ||
                                i_cmd.data != fbl_pkg::magic_byte(r_byte_idx)) begin
                                n_phase = fbl_pkg::PH_BAD;
                            end else if (idx_inc == fbl_pkg::MAGIC_LEN) begin
                                n_byte_idx = 4'd0;
                                n_chunk    = 3'd0;
                                n_phase    = fbl_pkg::PH_KEY;
                            end else begin
                                n_byte_idx = idx_inc;
                            end
                        end
                        fbl_pkg::PH_KEY: begin
                            n_phase = fbl_pkg::PH_LEN_HI;
                        end
                        fbl_pkg::PH_LEN_HI: begin
                            n_skip  = {i_cmd.data, 8'h00};
                            n_phase = fbl_pkg::PH_LEN_LO;
                        end
                        fbl_pkg::PH_LEN_LO: begin
                            n_skip = skip_full;
                            if (skip_full == 16'd0) begin
                                n_chunk = chunk_inc;
                                n_phase = (chunk_inc >= CHUNKS_LAST) ?
                                          fbl_pkg::PH_FINAL_KEY : fbl_pkg::PH_KEY;
                            end else begin
                                n_phase = fbl_pkg::PH_SKIP;
                            end
                        end
                        fbl_pkg::PH_SKIP: begin
                            n_skip = skip_dec;
                            if (skip_dec == 16'd0) begin
                                n_chunk = chunk_inc;
                                n_phase = (chunk_inc >= CHUNKS_LAST) ?
                                          fbl_pkg::PH_FINAL_KEY : fbl_pkg::PH_KEY;
                            end
                        end
                        fbl_pkg::PH_FINAL_KEY: begin
                            n_size     = 32'd0;
                            n_byte_idx = 4'd0;
                            n_phase    = fbl_pkg::PH_SIZE;
                        end
                        default: begin
                            // size capture, big-endian
                            n_size = {r_size[23:0], i_cmd.data};
                            if (idx_inc >= fbl_pkg::SIZE_BYTES) begin
                                n_byte_idx = 4'd0;
                                n_prog     = 1'b0;
                                n_phase    = fbl_pkg::PH_AWAIT_LOW;
                            end else begin
                                n_byte_idx = idx_inc;
                            end
                        end
                    endcase
                end else if (r_phase == fbl_pkg::PH_STREAM) begin
                    if (!i_cmd.init_hi) begin
                        n_phase = fbl_pkg::PH_INITFAIL;
                    end else begin
                        accepted = 1'b1;
                        svalid   = 1'b1;
                        sbyte    = i_cmd.data;
                        if (r_sent != 32'hFFFF_FFFF) begin
                            n_sent = r_sent + 32'd1;
                        end
                    end
                end
            end
            fbl_pkg::CMD_EOF: begin
                if (r_phase <= fbl_pkg::PH_SIZE) begin
                    accepted = 1'b1;
                    n_phase  = fbl_pkg::PH_TRUNC;
                end else if (r_phase == fbl_pkg::PH_STREAM) begin
                    accepted = 1'b1;
                    n_phase  = fbl_pkg::PH_DUMMY;
                end
            end
            fbl_pkg::CMD_TICK: begin
                unique case (r_phase)
                    fbl_pkg::PH_AWAIT_LOW: begin
                        if (!i_cmd.init_hi) begin
                            n_prog  = 1'b1;
                            n_phase = fbl_pkg::PH_AWAIT_HIGH;
                        end
                    end
                    fbl_pkg::PH_AWAIT_HIGH: begin
                        if (i_cmd.init_hi) begin
                            if (r_settle_ticks == 8'd0) begin
                                n_phase = fbl_pkg::PH_STREAM;
                            end else begin
                                n_settle = r_settle_ticks;
                                n_phase  = fbl_pkg::PH_SETTLE;
                            end
                        end
                    end
                    fbl_pkg::PH_SETTLE: begin
                        n_settle = settle_dec;
                        if (settle_dec == 8'd0) begin
                            n_phase = fbl_pkg::PH_STREAM;
                        end
                    end
                    fbl_pkg::PH_DUMMY: begin
                        // done wins over an INIT drop
                        if (i_cmd.done_hi) begin
                            n_phase = fbl_pkg::PH_OK;
                        end else if (!i_cmd.init_hi) begin
                            n_phase = fbl_pkg::PH_INITFAIL;
                        end else begin
                            svalid = 1'b1;
                            sbyte  = fbl_pkg::DUMMY_BYTE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        o_res.accepted      = accepted;
        o_res.serial_valid  = svalid;
        o_res.serial_byte   = sbyte;
        o_res.prog_level    = n_prog;
        o_res.status        = fbl_pkg::status_of(n_phase);
        o_res.expected_size = n_size;
        o_res.bytes_sent    = n_sent;
    end

    // loader state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fbl_pkg::PH_MAGIC;
            r_byte_idx <= 4'd0;
            r_chunk    <= 3'd0;
            r_skip     <= 16'd0;
            r_size     <= 32'd0;
            r_sent     <= 32'd0;
            r_settle   <= 8'd0;
            r_prog     <= 1'b1;
        end else if (go) begin
            r_phase    <= n_phase;
            r_byte_idx <= n_byte_idx;
            r_chunk    <= n_chunk;
            r_skip     <= n_skip;
            r_size     <= n_size;
            r_sent     <= n_sent;
            r_settle   <= n_settle;
            r_prog     <= n_prog;
        end
    end

    // settle tick register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= fbl_pkg::SETTLE_RESET;
        end else if (i_cfg_we) begin
            r_settle_ticks <= i_cfg_wdata;
        end
    end

endmodule

@@ hw/rtl/fpga_bitstream_loader.sv @@
// top level of the slave serial bit-file loader
//
//  channel  | handshake          | word
//  ---------+--------------------+----------------------------------------------
//  input    | push / full        | i_data  (op, file_byte, init_pin, done_pin)
//  result   | empty / pop        | o_data  (accepted .. bytes_sent)
//  config   | i_cfg_we           | i_cfg_wdata (settle_ticks)
//
// one word per cycle sustained while results are popped; a result goes from the
// command queue through the engine into the result queue, from which it can be
// popped; the engine waits while the result queue is full.
// reset is synchronous, active low, and empties both queues.
// with pop held low the result queue fills, then the command queue, then full
// rises; the parser advances whenever the result queue has room.
module fpga_bitstream_loader #(
    parameter int HEADER_CHUNKS = 4,
    parameter int QUEUE_DEPTH   = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  fbl_pkg::t_in_word  i_data,
    output logic               empty,
    input  logic               pop,
    output fbl_pkg::t_out_word o_data,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata
);

    localparam int CMD_W = $bits(fbl_pkg::t_cmd);
    localparam int RES_W = $bits(fbl_pkg::t_out_word);

    logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
    fbl_pkg::t_cmd      cmd_in, cmd_out;
    logic [CMD_W-1:0]   cmd_rdata;
    logic               res_push, res_full;
    fbl_pkg::t_out_word res_in;
    logic [RES_W-1:0]   res_rdata;

    // front: classify
    fbl_front u_front (
        .i_push     (push),
        .i_word     (i_data),
        .i_cmd_full (cmd_full),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // command queue between front and back
    fbl_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_rdata),
        .o_empty (cmd_empty)
    );

    assign cmd_out = fbl_pkg::t_cmd'(cmd_rdata);

    // back: loader engine
    fbl_engine #(
        .HEADER_CHUNKS (HEADER_CHUNKS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue toward the consumer
    fbl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign o_data = fbl_pkg::t_out_word'(res_rdata);

endmodule
